>>> design/bb3_pkg.sv
// bb3_pkg: shared types and constants of the 3x3 clipped box blur.
// Used by bb3_front, bb3_queue, bb3_back and box_blur_3x3_rgb_top.
`timescale 1ns / 1ps
package bb3_pkg;

  // one RGB pixel: blue in bits 7:0, green 15:8, red 23:16
  typedef logic [23:0] rgb_t;

  // per-beat control from the front part to the back part
  typedef struct packed {
    logic emit;      // this beat produces an output pixel
    logic top_ok;    // row above is inside the frame
    logic bot_ok;    // row below is inside the frame
    logic left_ok;   // column to the left is inside the frame
    logic right_ok;  // column to the right is inside the frame
    logic last;      // final output pixel of the frame
  } beat_ctl_t;

  localparam int QDEPTH = 4;
  localparam int RSHIFT = 20;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // ceil(2^20 / (2*n)): floor(x * recip(n) >> 20) == floor(x / (2n)) for x < 8192
  function automatic logic [19:0] recip(input logic [3:0] n);
    logic [19:0] r;
    unique case (n)
      4'd1:    r = 20'd524288;
      4'd2:    r = 20'd262144;
      4'd3:    r = 20'd174763;
      4'd4:    r = 20'd131072;
      4'd5:    r = 20'd104858;
      4'd6:    r = 20'd87382;
      4'd7:    r = 20'd74899;
      4'd8:    r = 20'd65536;
      4'd9:    r = 20'd58255;
      default: r = 20'd0;
    endcase
    return r;
  endfunction

endpackage

>>> design/bb3_queue.sv
// bb3_queue: small FIFO between the front and back parts.
// Depends on bb3_pkg for its depth.
`timescale 1ns / 1ps
module bb3_queue #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic         not_empty,
  output logic [W-1:0] pop_data
);
  import bb3_pkg::*;

  localparam int PW = $clog2(QDEPTH);

  logic [W-1:0]  mem [QDEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   fill;

  assign full      = (fill == (PW+1)'(QDEPTH));
  assign not_empty = (fill != '0);
  assign pop_data  = mem[rd_ptr];

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push && !full) wr_ptr <= wr_ptr + PW'(1);
      if (pop && not_empty) rd_ptr <= rd_ptr + PW'(1);
      unique case ({push && !full, pop && not_empty})
        2'b10:   fill <= fill + (PW+1)'(1);
        2'b01:   fill <= fill - (PW+1)'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

>>> design/bb3_front.sv
// bb3_front: accepts beats, tracks input and output positions, classifies
// each beat and pushes work into the queue. Holds the config registers. Uses bb3_pkg.
`timescale 1ns / 1ps
module bb3_front #(
  parameter int MAX_WIDTH = 1024,
  parameter int CW        = 10,
  parameter int EW        = 11
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [23:0]       s_tdata,
  input  logic              s_tuser,
  input  logic              q_full,
  output logic              push,
  output logic [CW-1:0]     push_c,
  output bb3_pkg::beat_ctl_t push_ctl,
  output bb3_pkg::rgb_t     push_pix
);
  import bb3_pkg::*;

  logic [10:0] frame_width;
  logic [15:0] frame_height;

  logic [EW-1:0] in_column, in_column_next;
  logic [17:0]   in_row, in_row_next;
  logic [EW-1:0] out_column, out_column_next;
  logic [15:0]   out_row, out_row_next;

  logic [EW-1:0] fw_x, w_eff, c, c_inc, oc_inc;
  logic [15:0]   h_eff;
  logic [16:0]   or_inc;
  logic          draining, accept, keep, emit;
  beat_ctl_t     ctl;

  // effective frame size
  always_comb begin
    fw_x = EW'(frame_width);
    if (frame_width == '0) w_eff = EW'(1);
    else if (fw_x > EW'(MAX_WIDTH)) w_eff = EW'(MAX_WIDTH);
    else w_eff = fw_x;
    h_eff = (frame_height == '0) ? 16'd1 : frame_height;
  end

  // classify the beat and work out the border masks
  always_comb begin
    accept   = s_tvalid && s_tready;
    draining = (in_row >= {2'b00, h_eff});
    keep     = !(s_tuser == OP_DRAIN && !draining);
    c        = (in_column >= w_eff) ? '0 : in_column;
    c_inc    = c + EW'(1);
    emit     = (in_row >= 18'd2) || (in_row == 18'd1 && c != '0);
    oc_inc   = out_column + EW'(1);
    or_inc   = {1'b0, out_row} + 17'd1;

    ctl.emit     = emit;
    ctl.top_ok   = (out_row != '0);
    ctl.bot_ok   = (or_inc < {1'b0, h_eff});
    ctl.left_ok  = (out_column != '0);
    ctl.right_ok = (oc_inc < w_eff);
    ctl.last     = !ctl.bot_ok && !ctl.right_ok;

    in_column_next  = in_column;
    in_row_next     = in_row;
    out_column_next = out_column;
    out_row_next    = out_row;
    if (accept && keep) begin
      if (c_inc >= w_eff) begin
        in_column_next = '0;
        in_row_next    = in_row + 18'd1;
      end else begin
        in_column_next = c_inc;
      end
      if (emit) begin
        if (ctl.last) begin
          in_column_next  = '0;
          in_row_next     = '0;
          out_column_next = '0;
          out_row_next    = '0;
        end else if (oc_inc >= w_eff) begin
          out_column_next = '0;
          out_row_next    = or_inc[15:0];
        end else begin
          out_column_next = oc_inc;
        end
      end
    end
  end

  assign s_tready = !q_full;
  assign push     = accept && keep;
  assign push_c   = c[CW-1:0];
  assign push_ctl = ctl;
  assign push_pix = draining ? '0 : s_tdata;

  // config registers and position counters; a config write restarts the frame
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= 11'd1024;
      frame_height <= 16'd768;
      in_column    <= '0;
      in_row       <= '0;
      out_column   <= '0;
      out_row      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WIDTH:  frame_width  <= cfg_data[10:0];
        CFG_HEIGHT: frame_height <= cfg_data;
        default:    frame_height <= frame_height;
      endcase
      in_column  <= '0;
      in_row     <= '0;
      out_column <= '0;
      out_row    <= '0;
    end else begin
      in_column  <= in_column_next;
      in_row     <= in_row_next;
      out_column <= out_column_next;
      out_row    <= out_row_next;
    end
  end

endmodule

>>> design/bb3_back.sv
// bb3_back: line stores, 3x3 window, clipped sums and rounded division.
// Pops work from bb3_queue; uses bb3_pkg for types and the reciprocal table.
`timescale 1ns / 1ps
module bb3_back #(
  parameter int MAX_WIDTH = 1024,
  parameter int CW        = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  output logic               q_ready,
  input  logic [CW-1:0]      q_c,
  input  bb3_pkg::beat_ctl_t q_ctl,
  input  bb3_pkg::rgb_t      q_pix,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [23:0]        m_tdata,
  output logic               m_tlast
);
  import bb3_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_UPD  = 5'b00010,
    S_SUM  = 5'b00100,
    S_MUL  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state, state_next;

  rgb_t      line_top [MAX_WIDTH];
  rgb_t      line_mid [MAX_WIDTH];
  rgb_t      top_rd, mid_rd;
  logic [CW-1:0] cur_c;
  beat_ctl_t cur_ctl;
  rgb_t      cur_pix;
  rgb_t      win [9];

  logic [11:0] sum [3];
  logic [3:0]  count;
  logic [32:0] prod [3];
  logic [11:0] sum_c [3];
  logic [3:0]  count_c;
  logic        use_tap;

  // state sequencing: one beat at a time
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (q_valid) state_next = S_UPD;
      S_UPD:  state_next = cur_ctl.emit ? S_SUM : S_IDLE;
      S_SUM:  state_next = S_MUL;
      S_MUL:  state_next = S_OUT;
      S_OUT:  if (m_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  assign q_ready = (state == S_IDLE);

  // latch the popped beat
  always_ff @(posedge clk) begin
    if (state == S_IDLE && q_valid) begin
      cur_c   <= q_c;
      cur_ctl <= q_ctl;
      cur_pix <= q_pix;
    end
  end

  // line stores: read on pop, rotate the column on update
  always_ff @(posedge clk) begin
    if (state == S_IDLE && q_valid) top_rd <= line_top[q_c];
    if (state == S_UPD) line_top[cur_c] <= mid_rd;
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && q_valid) mid_rd <= line_mid[q_c];
    if (state == S_UPD) line_mid[cur_c] <= cur_pix;
  end

  // window shifts left, new column enters on the right
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) win[i] <= '0;
    end else if (state == S_UPD) begin
      for (int r = 0; r < 3; r++) begin
        win[r*3]   <= win[r*3+1];
        win[r*3+1] <= win[r*3+2];
      end
      win[2] <= top_rd;
      win[5] <= mid_rd;
      win[8] <= cur_pix;
    end
  end

  // clipped per-channel sums and tap count
  always_comb begin
    for (int ch = 0; ch < 3; ch++) sum_c[ch] = '0;
    count_c = '0;
    for (int dr = 0; dr < 3; dr++) begin
      for (int dc = 0; dc < 3; dc++) begin
        use_tap = !((dr == 0 && !cur_ctl.top_ok) || (dr == 2 && !cur_ctl.bot_ok) ||
                    (dc == 0 && !cur_ctl.left_ok) || (dc == 2 && !cur_ctl.right_ok));
        if (use_tap) begin
          for (int ch = 0; ch < 3; ch++) begin
            sum_c[ch] = sum_c[ch] + 12'(win[dr*3+dc][ch*8 +: 8]);
          end
          count_c = count_c + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_SUM) begin
      sum   <= sum_c;
      count <= count_c;
    end
  end

  // (2*sum + n) * ceil(2^20 / 2n), quotient in bits 27:20
  always_ff @(posedge clk) begin
    if (state == S_MUL) begin
      for (int ch = 0; ch < 3; ch++) begin
        prod[ch] <= 33'(({1'b0, sum[ch], 1'b0} + 14'(count))) * 33'(recip(count));
      end
    end
  end

  assign m_tvalid = (state == S_OUT);
  assign m_tdata  = {prod[2][RSHIFT +: 8], prod[1][RSHIFT +: 8], prod[0][RSHIFT +: 8]};
  assign m_tlast  = cur_ctl.last;

  // the mean always has at least the center tap
  a_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL) |-> (count != 4'd0))
    else $error("empty tap count");

  // quotient never exceeds one byte
  a_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |-> (prod[0][32:RSHIFT] < 13'd256 && prod[1][32:RSHIFT] < 13'd256 &&
                          prod[2][32:RSHIFT] < 13'd256))
    else $error("mean out of range");

  // a line store update always follows a pop
  a_upd: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPD) |-> ($past(state) == S_IDLE && $past(q_valid)))
    else $error("update without pop");

endmodule

>>> design/box_blur_3x3_rgb_top.sv
// box_blur_3x3_rgb_top: 3x3 border-clipped RGB box blur, top level.
// Instantiates bb3_front, bb3_queue and bb3_back; uses bb3_pkg.
//
//  channel | direction | fields
//  s_*     | in        | tdata: blue, green, red; tuser: op (0 pixel, 1 drain)
//  m_*     | out       | tdata: blue, green, red; tlast: frame_end
//  cfg_*   | in        | index 0 frame_width, 1 frame_height
//
// In the back part each beat goes through line store read and window update; a beat with
// an output also goes through sum, reciprocal multiply and output hold.
// The front accepts a beat per cycle while the 4-entry queue has room.
// Reset (rst, synchronous) clears counters and window; line stores are not cleared.
// A stalled output holds the back part; the front keeps filling the queue.
`timescale 1ns / 1ps
module box_blur_3x3_rgb_top #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [7:0] blue, [15:8] green, [23:16] red
  input  logic        s_tuser,   // op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] blue, [15:8] green, [23:16] red
  output logic        m_tlast
);
  import bb3_pkg::*;

  localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int EW0 = $clog2(MAX_WIDTH + 1);
  localparam int EW  = (EW0 > 11) ? EW0 : 11;
  localparam int QW  = CW + $bits(beat_ctl_t) + $bits(rgb_t);

  logic          push, q_full, q_valid, q_ready;
  logic [CW-1:0] push_c;
  beat_ctl_t     push_ctl;
  rgb_t          push_pix;
  logic [QW-1:0] q_out;

  bb3_front #(.MAX_WIDTH(MAX_WIDTH), .CW(CW), .EW(EW)) u_front (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .q_full, .push, .push_c, .push_ctl, .push_pix
  );

  bb3_queue #(.W(QW)) u_queue (
    .clk, .rst,
    .push, .push_data({push_c, push_ctl, push_pix}), .full(q_full),
    .pop(q_ready), .not_empty(q_valid), .pop_data(q_out)
  );

  bb3_back #(.MAX_WIDTH(MAX_WIDTH), .CW(CW)) u_back (
    .clk, .rst,
    .q_valid, .q_ready,
    .q_c(q_out[QW-1 -: CW]),
    .q_ctl(beat_ctl_t'(q_out[$bits(rgb_t) +: $bits(beat_ctl_t)])),
    .q_pix(q_out[$bits(rgb_t)-1:0]),
    .m_tvalid, .m_tready, .m_tdata, .m_tlast
  );

endmodule
